// ===== rtl/mkbc_pkg.sv =====
// Shared types, constants and MD5 tables for the MPPE key block cipher.
`timescale 1ns / 1ps

package mkbc_pkg;

   localparam int SECRET_MAX_BYTES = 32;
   localparam int MAX_BLOCKS       = 16;
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [2:0] CSR_SECRET0    = 3'd0;
   localparam logic [2:0] CSR_SECRET1    = 3'd1;
   localparam logic [2:0] CSR_SECRET2    = 3'd2;
   localparam logic [2:0] CSR_SECRET3    = 3'd3;
   localparam logic [2:0] CSR_SECRET_LEN = 3'd4;
   localparam logic [2:0] CSR_AUTH_HI    = 3'd5;
   localparam logic [2:0] CSR_AUTH_LO    = 3'd6;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_LEN   = 2'd1;
   localparam logic [1:0] ST_TOO_MANY  = 2'd2;

   localparam logic FUNC_DECRYPT = 1'b1;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   typedef struct packed {
      logic        func;
      logic        first_block;
      logic        last_block;
      logic [15:0] salt;
      logic [63:0] data_hi;
      logic [63:0] data_lo;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } front_out_type;

   typedef struct packed {
      logic [255:0] secret;
      logic [5:0]   secret_bytes;
      logic [127:0] auth;
   } cfg_type;

   function automatic logic [31:0] md5_k(input logic [5:0] idx);
      logic [31:0] k;
      unique case (idx)
         6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756; 6'd2:  k = 32'h242070db;
         6'd3:  k = 32'hc1bdceee; 6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501; 6'd8:  k = 32'h698098d8;
         6'd9:  k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
         6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
         6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
         6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
         6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
         6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
         6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
         6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
         6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
         default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] md5_s(input logic [3:0] idx);
      logic [4:0] s;
      unique case (idx)
         4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
         4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
         4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
         4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15;
         default: s = 5'd21;
      endcase
      return s;
   endfunction

   function automatic logic [31:0] bswap32(input logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

endpackage

// ===== rtl/mppe_key_block_cipher.sv =====
// Top level of the MPPE key block cipher: CSRs, request queue and MD5 back end.
//
//   channel  | ports                         | handshake
//   ---------+-------------------------------+-------------------------------
//   request  | req_func .. req_data_lo       | push and !full at clock edge
//   response | rsp_result_hi .. rsp_status   | pop and !empty at clock edge
//   csr      | csr_wr_en, csr_index, csr_data| csr_wr_en at clock edge
//
// In the back end each request is loaded into the message block, run through
// 64 MD5 rounds on a single round unit, then finished; the round loop sets the rate.
// Reset is synchronous and clears queue pointers, chaining state and CSRs.
// A two-entry request queue keeps taking requests while a response waits on pop;
// the back end holds a finished digest until the response register is free.
`timescale 1ns / 1ps

module mppe_key_block_cipher (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_func,
   input  logic        req_first_block,
   input  logic        req_last_block,
   input  logic [15:0] req_salt,
   input  logic [63:0] req_data_hi,
   input  logic [63:0] req_data_lo,
   output logic        empty,
   input  logic        pop,
   output logic [63:0] rsp_result_hi,
   output logic [63:0] rsp_result_lo,
   output logic        rsp_final_block,
   output logic [7:0]  rsp_key_length,
   output logic [1:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic [63:0]               secret_ff [4];
   logic [5:0]                slen_ff;
   logic [63:0]               auth_hi_ff, auth_lo_ff;
   mkbc_pkg::cfg_type         cfg;
   mkbc_pkg::item_type        item;
   mkbc_pkg::front_out_type   head;
   logic                      deq, out_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            secret_ff[i] <= 64'd0;
         end
         slen_ff    <= 6'd0;
         auth_hi_ff <= 64'd0;
         auth_lo_ff <= 64'd0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            mkbc_pkg::CSR_SECRET0:    secret_ff[0] <= csr_data;
            mkbc_pkg::CSR_SECRET1:    secret_ff[1] <= csr_data;
            mkbc_pkg::CSR_SECRET2:    secret_ff[2] <= csr_data;
            mkbc_pkg::CSR_SECRET3:    secret_ff[3] <= csr_data;
            mkbc_pkg::CSR_SECRET_LEN: slen_ff      <= csr_data[5:0];
            mkbc_pkg::CSR_AUTH_HI:    auth_hi_ff   <= csr_data;
            mkbc_pkg::CSR_AUTH_LO:    auth_lo_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   assign cfg.secret       = {secret_ff[0], secret_ff[1], secret_ff[2], secret_ff[3]};
   assign cfg.secret_bytes = slen_ff;
   assign cfg.auth         = {auth_hi_ff, auth_lo_ff};

   assign item.func        = req_func;
   assign item.first_block = req_first_block;
   assign item.last_block  = req_last_block;
   assign item.salt        = req_salt;
   assign item.data_hi     = req_data_hi;
   assign item.data_lo     = req_data_lo;

   mkbc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .item_in (item),
      .full    (full),
      .deq     (deq),
      .head    (head)
   );

   mkbc_core u_core (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .head           (head),
      .deq            (deq),
      .out_valid      (out_valid),
      .out_pop        (pop),
      .out_hi         (rsp_result_hi),
      .out_lo         (rsp_result_lo),
      .out_final      (rsp_final_block),
      .out_key_length (rsp_key_length),
      .out_status     (rsp_status)
   );

   assign empty = !out_valid;

   // A bad length byte is only reported on the last block.
   a_bad_len_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status == mkbc_pkg::ST_BAD_LEN) |-> rsp_final_block)
      else $error("bad length status on a non-final block");

   // A key length is only reported on the last block.
   a_klen_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_key_length != 8'd0) |-> rsp_final_block)
      else $error("key length on a non-final block");

   // The back end never takes a request from an empty queue.
   a_deq_valid: assert property (@(posedge clock) disable iff (reset)
      deq |-> head.valid)
      else $error("dequeue from empty request queue");

   // A response that is not popped stays in place.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_result_hi) && $stable(rsp_status)))
      else $error("response changed while waiting");

endmodule

// ===== rtl/mkbc_front.sv =====
// Front end: request queue between the input port and the MD5 back end.
`timescale 1ns / 1ps

module mkbc_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mkbc_pkg::item_type     item_in,
   output logic                   full,
   input  logic                   deq,
   output mkbc_pkg::front_out_type head
);

   mkbc_pkg::item_type q_ff [mkbc_pkg::QUEUE_DEPTH];
   logic                          wr_ptr_ff, wr_ptr_in;
   logic                          rd_ptr_ff, rd_ptr_in;
   logic [1:0]                    count_ff, count_in;
   logic                          do_push, do_pop;

   assign full    = (count_ff == 2'(mkbc_pkg::QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = deq && (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= item_in;
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = q_ff[rd_ptr_ff];

endmodule

// ===== rtl/mkbc_core.sv =====
// Back end: message build, 64-round MD5 engine, block chaining and result register.
`timescale 1ns / 1ps

module mkbc_core (
   input  logic                    clock,
   input  logic                    reset,
   input  mkbc_pkg::cfg_type       cfg,
   input  mkbc_pkg::front_out_type head,
   output logic                    deq,
   output logic                    out_valid,
   input  logic                    out_pop,
   output logic [63:0]             out_hi,
   output logic [63:0]             out_lo,
   output logic                    out_final,
   output logic [7:0]              out_key_length,
   output logic [1:0]              out_status
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_ROUND = 3'b010,
      S_FIN   = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [5:0]         round_ff, round_in;
   logic [31:0]        a_ff, b_ff, c_ff, d_ff;
   logic [31:0]        a_in, b_in, c_in, d_in;
   logic [31:0]        words_ff [16];
   logic [31:0]        words_in [16];
   mkbc_pkg::item_type item_ff;
   logic [127:0]       prev_ff;
   logic [7:0]         plb_ff, plb_in;
   logic [4:0]         count_ff, count_in;
   logic               ovalid_ff, ovalid_in;
   logic [63:0]        ohi_ff, olo_ff;
   logic               ofinal_ff;
   logic [7:0]         oklen_ff, oklen_in;
   logic [1:0]         ostat_ff, ostat_in;

   logic [7:0]         mb [64];
   logic [127:0]       blk;
   logic [5:0]         slen;
   logic [8:0]         bits;
   logic               start, finish, out_free;
   logic [1:0]         rnd;
   logic [3:0]         g;
   logic [31:0]        f, t, rot;
   logic [63:0]        rot2;
   logic [63:0]        khi, klo, rhi, rlo;
   logic [8:0]         limit;

   assign out_free = !ovalid_ff || out_pop;
   assign start    = (state_ff == S_IDLE) && head.valid;
   assign finish   = (state_ff == S_FIN) && out_free;
   assign deq      = start;

   // Message block: secret, 16 chained bytes (auth value on a first block), salt on a first block, MD5 padding.
   always_comb begin
      int j;
      int n;
      slen = (cfg.secret_bytes > 6'(mkbc_pkg::SECRET_MAX_BYTES)) ?
             6'(mkbc_pkg::SECRET_MAX_BYTES) : cfg.secret_bytes;
      blk  = head.item.first_block ? cfg.auth : prev_ff;
      n    = int'(slen) + 16 + (head.item.first_block ? 2 : 0);
      bits = 9'(n * 8);
      for (int i = 0; i < 64; i++) begin
         j = i - int'(slen);
         if (i < int'(slen)) begin
            mb[i] = cfg.secret[255 - 8 * (i % 32) -: 8];
         end else if (j < 16) begin
            mb[i] = blk[127 - 8 * (j % 16) -: 8];
         end else if (j == 16 && head.item.first_block) begin
            mb[i] = head.item.salt[15:8];
         end else if (j == 17 && head.item.first_block) begin
            mb[i] = head.item.salt[7:0];
         end else if (i == n) begin
            mb[i] = 8'h80;
         end else if (i == 56) begin
            mb[i] = bits[7:0];
         end else if (i == 57) begin
            mb[i] = {7'd0, bits[8]};
         end else begin
            mb[i] = 8'h00;
         end
      end
      for (int w = 0; w < 16; w++) begin
         words_in[w] = {mb[4 * w + 3], mb[4 * w + 2], mb[4 * w + 1], mb[4 * w]};
      end
   end

   // One MD5 round per cycle.
   always_comb begin
      rnd = round_ff[5:4];
      unique case (rnd)
         2'd0: begin
            f = (b_ff & c_ff) | (~b_ff & d_ff);
            g = round_ff[3:0];
         end
         2'd1: begin
            f = (d_ff & b_ff) | (~d_ff & c_ff);
            g = 4'({round_ff[3:0], 2'b00} + {2'b00, round_ff[3:0]} + 6'd1);
         end
         2'd2: begin
            f = b_ff ^ c_ff ^ d_ff;
            g = 4'({round_ff[3:0], 1'b0} + {1'b0, round_ff[3:0]} + 5'd5);
         end
         default: begin
            f = c_ff ^ (b_ff | ~d_ff);
            g = 4'({round_ff[3:0], 3'b000} - {3'b000, round_ff[3:0]});
         end
      endcase
      t    = f + a_ff + mkbc_pkg::md5_k(round_ff) + words_ff[g];
      rot2 = {t, t} << mkbc_pkg::md5_s({rnd, round_ff[1:0]});
      rot  = rot2[63:32];
   end

   // Keystream, transform, chain state and status.
   always_comb begin
      khi = {mkbc_pkg::bswap32(mkbc_pkg::IV_A + a_ff), mkbc_pkg::bswap32(mkbc_pkg::IV_B + b_ff)};
      klo = {mkbc_pkg::bswap32(mkbc_pkg::IV_C + c_ff), mkbc_pkg::bswap32(mkbc_pkg::IV_D + d_ff)};
      rhi = item_ff.data_hi ^ khi;
      rlo = item_ff.data_lo ^ klo;
      plb_in   = plb_ff;
      count_in = count_ff;
      ostat_in = mkbc_pkg::ST_OK;
      oklen_in = 8'd0;
      if (item_ff.first_block) begin
         count_in = 5'd1;
         plb_in   = (item_ff.func == mkbc_pkg::FUNC_DECRYPT) ? rhi[63:56] : item_ff.data_hi[63:56];
      end else if (count_ff < 5'(mkbc_pkg::MAX_BLOCKS)) begin
         count_in = count_ff + 5'd1;
      end else begin
         count_in = 5'(mkbc_pkg::MAX_BLOCKS);
         ostat_in = mkbc_pkg::ST_TOO_MANY;
      end
      limit = {count_in, 4'b0000} - 9'd1;
      if (item_ff.func == mkbc_pkg::FUNC_DECRYPT && item_ff.last_block) begin
         oklen_in = plb_in;
         if (ostat_in == mkbc_pkg::ST_OK && (plb_in == 8'd0 || {1'b0, plb_in} > limit)) begin
            ostat_in = mkbc_pkg::ST_BAD_LEN;
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      round_in  = round_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      c_in      = c_ff;
      d_in      = d_ff;
      ovalid_in = ovalid_ff && !out_pop;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               a_in     = mkbc_pkg::IV_A;
               b_in     = mkbc_pkg::IV_B;
               c_in     = mkbc_pkg::IV_C;
               d_in     = mkbc_pkg::IV_D;
               round_in = 6'd0;
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            a_in     = d_ff;
            d_in     = c_ff;
            c_in     = b_ff;
            b_in     = b_ff + rot;
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = S_FIN;
            end
         end
         default: begin
            // hold the digest until the result register frees up
            if (finish) begin
               ovalid_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ovalid_ff <= 1'b0;
         prev_ff   <= 128'd0;
         plb_ff    <= 8'd0;
         count_ff  <= 5'd0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
         if (finish) begin
            prev_ff  <= (item_ff.func == mkbc_pkg::FUNC_DECRYPT) ?
                        {item_ff.data_hi, item_ff.data_lo} : {rhi, rlo};
            plb_ff   <= plb_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      round_ff <= round_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      d_ff     <= d_in;
      if (start) begin
         item_ff <= head.item;
         for (int w = 0; w < 16; w++) begin
            words_ff[w] <= words_in[w];
         end
      end
      if (finish) begin
         ohi_ff    <= rhi;
         olo_ff    <= rlo;
         ofinal_ff <= item_ff.last_block;
         oklen_ff  <= oklen_in;
         ostat_ff  <= ostat_in;
      end
   end

   assign out_valid      = ovalid_ff;
   assign out_hi         = ohi_ff;
   assign out_lo         = olo_ff;
   assign out_final      = ofinal_ff;
   assign out_key_length = oklen_ff;
   assign out_status     = ostat_ff;

endmodule

// ===== tb/sv/mppe_key_block_cipher_chk.sv =====
// Checker for the MPPE key block cipher: predicts each response and compares it.
`timescale 1ns / 1ps

module mppe_key_block_cipher_chk (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic        req_func,
   input  logic        req_first_block,
   input  logic        req_last_block,
   input  logic [15:0] req_salt,
   input  logic [63:0] req_data_hi,
   input  logic [63:0] req_data_lo,
   input  logic        empty,
   input  logic        pop,
   input  logic [63:0] rsp_result_hi,
   input  logic [63:0] rsp_result_lo,
   input  logic        rsp_final_block,
   input  logic [7:0]  rsp_key_length,
   input  logic [1:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   output int          fail_count,
   output int          pending,
   output int          checked,
   output int          bad_len_seen,
   output int          too_many_seen
);

   typedef struct packed {
      logic [63:0] result_hi;
      logic [63:0] result_lo;
      logic        final_block;
      logic [7:0]  key_length;
      logic [1:0]  status;
   } cipher_result_type;

   // shadow of the CSRs
   logic [63:0] secret_w [4];
   logic [5:0]  secret_bytes;
   logic [63:0] auth_hi, auth_lo;

   // chaining state
   logic [63:0] chain_hi, chain_lo;
   logic [7:0]  length_byte;
   int          block_cnt;

   cipher_result_type expected_q [$];

   // sine-derived round constant
   function automatic logic [31:0] round_const(input int i);
      real    x;
      longint v;
      x = $sin(i + 1);
      if (x < 0.0) x = -x;
      v = longint'($floor(x * 4294967296.0));
      return v[31:0];
   endfunction

   function automatic logic [127:0] md5_keystream(input logic [63:0] hi, input logic [63:0] lo,
                                                  input logic with_salt,
                                                  input logic [15:0] salt);
      int unsigned rot [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
      logic [7:0]   msg [128];
      logic [31:0]  h [4];
      logic [31:0]  w [16];
      logic [31:0]  a, b, c, d, f, t;
      logic [63:0]  nbits;
      logic [127:0] ks;
      int           n, slen, nblk, g, r, sh;
      for (int i = 0; i < 128; i++) msg[i] = 8'h00;
      n = 0;
      slen = (int'(secret_bytes) > mkbc_pkg::SECRET_MAX_BYTES) ?
             mkbc_pkg::SECRET_MAX_BYTES : int'(secret_bytes);
      for (int i = 0; i < slen; i++) begin
         msg[n] = secret_w[i / 8][63 - 8 * (i % 8) -: 8];
         n++;
      end
      for (int i = 0; i < 8; i++) begin
         msg[n] = hi[63 - 8 * i -: 8];
         n++;
      end
      for (int i = 0; i < 8; i++) begin
         msg[n] = lo[63 - 8 * i -: 8];
         n++;
      end
      if (with_salt) begin
         msg[n] = salt[15:8];
         msg[n + 1] = salt[7:0];
         n += 2;
      end
      nbits = 64'(n) * 8;
      msg[n] = 8'h80;
      nblk = (n + 8) / 64 + 1;
      for (int i = 0; i < 8; i++) msg[nblk * 64 - 8 + i] = nbits[8 * i +: 8];
      h[0] = 32'h67452301; h[1] = 32'hefcdab89; h[2] = 32'h98badcfe; h[3] = 32'h10325476;
      for (int blk = 0; blk < nblk; blk++) begin
         for (int i = 0; i < 16; i++)
            w[i] = {msg[64 * blk + 4 * i + 3], msg[64 * blk + 4 * i + 2],
                    msg[64 * blk + 4 * i + 1], msg[64 * blk + 4 * i]};
         a = h[0]; b = h[1]; c = h[2]; d = h[3];
         for (int i = 0; i < 64; i++) begin
            r = i / 16;
            case (r)
               0: begin f = (b & c) | (~b & d); g = i; end
               1: begin f = (d & b) | (~d & c); g = (5 * i + 1) % 16; end
               2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
               default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
            endcase
            t = f + a + round_const(i) + w[g];
            sh = int'(rot[r * 4 + i % 4]);
            a = d; d = c; c = b;
            b = b + ((t << sh) | (t >> (32 - sh)));
         end
         h[0] += a; h[1] += b; h[2] += c; h[3] += d;
      end
      for (int i = 0; i < 16; i++) ks[127 - 8 * i -: 8] = h[i / 4][8 * (i % 4) +: 8];
      return ks;
   endfunction

   // advance the chaining state by one request and return its response
   function automatic cipher_result_type cipher_block(input logic func, input logic first,
                                                      input logic last,
                                                      input logic [15:0] salt,
                                                      input logic [63:0] dhi,
                                                      input logic [63:0] dlo);
      cipher_result_type res;
      logic [127:0]      ks;
      int                plen;
      if (first) ks = md5_keystream(auth_hi, auth_lo, 1'b1, salt);
      else ks = md5_keystream(chain_hi, chain_lo, 1'b0, 16'h0);
      res.result_hi = dhi ^ ks[127:64];
      res.result_lo = dlo ^ ks[63:0];
      res.final_block = last;
      res.key_length = 8'h00;
      res.status = mkbc_pkg::ST_OK;
      if (first) begin
         block_cnt = 1;
         length_byte = (func == mkbc_pkg::FUNC_DECRYPT) ? res.result_hi[63:56] : dhi[63:56];
      end else if (block_cnt < mkbc_pkg::MAX_BLOCKS) begin
         block_cnt++;
      end else begin
         block_cnt = mkbc_pkg::MAX_BLOCKS;
         res.status = mkbc_pkg::ST_TOO_MANY;
      end
      if (func == mkbc_pkg::FUNC_DECRYPT) begin
         chain_hi = dhi;
         chain_lo = dlo;
         if (last) begin
            plen = 16 * block_cnt;
            res.key_length = length_byte;
            if (res.status == mkbc_pkg::ST_OK &&
                (length_byte == 8'd0 || int'(length_byte) > plen - 1))
               res.status = mkbc_pkg::ST_BAD_LEN;
         end
      end else begin
         chain_hi = res.result_hi;
         chain_lo = res.result_lo;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      cipher_result_type want, got;
      if (reset) begin
         for (int i = 0; i < 4; i++) secret_w[i] <= '0;
         secret_bytes <= '0;
         auth_hi <= '0;
         auth_lo <= '0;
         chain_hi = '0;
         chain_lo = '0;
         length_byte = '0;
         block_cnt = 0;
         expected_q.delete();
         fail_count <= 0;
         pending <= 0;
         checked <= 0;
         bad_len_seen <= 0;
         too_many_seen <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               mkbc_pkg::CSR_SECRET0:    secret_w[0] <= csr_data;
               mkbc_pkg::CSR_SECRET1:    secret_w[1] <= csr_data;
               mkbc_pkg::CSR_SECRET2:    secret_w[2] <= csr_data;
               mkbc_pkg::CSR_SECRET3:    secret_w[3] <= csr_data;
               mkbc_pkg::CSR_SECRET_LEN: secret_bytes <= csr_data[5:0];
               mkbc_pkg::CSR_AUTH_HI:    auth_hi <= csr_data;
               mkbc_pkg::CSR_AUTH_LO:    auth_lo <= csr_data;
               default: ;
            endcase
         end
         if (pop && !empty) begin
            got = '{rsp_result_hi, rsp_result_lo, rsp_final_block, rsp_key_length, rsp_status};
            if (expected_q.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: response with nothing expected: %h", $realtime, got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               checked <= checked + 1;
               if (got.status == mkbc_pkg::ST_BAD_LEN) bad_len_seen <= bad_len_seen + 1;
               if (got.status == mkbc_pkg::ST_TOO_MANY) too_many_seen <= too_many_seen + 1;
               if (got !== want) begin
                  if (fail_count < 10)
                     $display({"%0t: mismatch exp hi=%h lo=%h fin=%b len=%h st=%0d",
                               " got hi=%h lo=%h fin=%b len=%h st=%0d"}, $realtime,
                              want.result_hi, want.result_lo, want.final_block,
                              want.key_length, want.status, got.result_hi, got.result_lo,
                              got.final_block, got.key_length, got.status);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (push && !full)
            expected_q.push_back(cipher_block(req_func, req_first_block, req_last_block,
                                              req_salt, req_data_hi, req_data_lo));
         pending <= expected_q.size();
      end
   end

endmodule

// ===== tb/sv/mppe_key_block_cipher_tb.sv =====
// Testbench top for the MPPE key block cipher: stimulus, idling and verdict.
`timescale 1ns / 1ps

module mppe_key_block_cipher_tb;

   localparam int IDLE_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic        req_func = 1'b0;
   logic        req_first_block = 1'b0;
   logic        req_last_block = 1'b0;
   logic [15:0] req_salt = '0;
   logic [63:0] req_data_hi = '0;
   logic [63:0] req_data_lo = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [63:0] rsp_result_hi, rsp_result_lo;
   logic        rsp_final_block;
   logic [7:0]  rsp_key_length;
   logic [1:0]  rsp_status;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   int fail_count, pending, checked, bad_len_seen, too_many_seen;
   int requests_sent = 0;
   int settings_run = 0;
   int burst_left = 0;
   int idle_cycles = 0;
   int pop_mode = 0;
   int pop_cycle = 0;

   always #5 clock = ~clock;

   mppe_key_block_cipher i_dut (.*);

   mppe_key_block_cipher_chk i_chk (.*);

   // receiver: stall pattern is redrawn at random from four pop modes
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         pop_cycle++;
         if (pop_cycle % 300 == 0) pop_mode = int'($urandom_range(0, 3));
         case (pop_mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 3) != 0);
            2: pop <= 1'($urandom_range(0, 1));
            default: pop <= ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL mppe_key_block_cipher");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   task automatic send(input logic func, input logic first, input logic last,
                       input logic [15:0] salt, input logic [63:0] dhi, input logic [63:0] dlo);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 90));
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = int'($urandom_range(1, 8));
      end
      burst_left--;
      push <= 1'b1;
      req_func <= func;
      req_first_block <= first;
      req_last_block <= last;
      req_salt <= salt;
      req_data_hi <= dhi;
      req_data_lo <= dlo;
      do @(posedge clock); while (full);
      requests_sent++;
   endtask

   // hold off until every response is back and the back end is quiet
   task automatic drain();
      push <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csrs(input logic [63:0] s0, input logic [63:0] s1,
                             input logic [63:0] s2, input logic [63:0] s3,
                             input logic [63:0] slen,
                             input logic [63:0] ahi, input logic [63:0] alo);
      logic [63:0] vals [7];
      logic [2:0]  idx [7];
      vals = '{s0, s1, s2, s3, slen, ahi, alo};
      idx = '{mkbc_pkg::CSR_SECRET0, mkbc_pkg::CSR_SECRET1, mkbc_pkg::CSR_SECRET2,
              mkbc_pkg::CSR_SECRET3, mkbc_pkg::CSR_SECRET_LEN, mkbc_pkg::CSR_AUTH_HI,
              mkbc_pkg::CSR_AUTH_LO};
      for (int i = 0; i < 7; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx[i];
         csr_data <= vals[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      @(posedge clock);
      settings_run++;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [15:0] rand16();
      return 16'($urandom_range(0, 16'hffff));
   endfunction

   // one key of nblk blocks; most encrypt keys carry a plausible length byte
   task automatic send_key(input logic func, input int nblk);
      logic [63:0] dhi;
      int          maxlen;
      for (int b = 0; b < nblk; b++) begin
         dhi = rand64();
         if (b == 0 && func != mkbc_pkg::FUNC_DECRYPT && $urandom_range(0, 3) != 0) begin
            maxlen = 16 * nblk - 1;
            if (maxlen > 255) maxlen = 255;
            dhi[63:56] = 8'($urandom_range(1, maxlen));
         end
         send(func, b == 0, b == nblk - 1, rand16(), dhi, rand64());
      end
   endtask

   task automatic random_phase(input int count);
      int start;
      int nblk;
      start = requests_sent;
      while (requests_sent - start < count) begin
         if ($urandom_range(0, 9) == 0) begin
            // noise: any flag combination
            send(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 rand16(), rand64(), rand64());
         end else begin
            nblk = ($urandom_range(0, 11) == 0) ? int'($urandom_range(15, 18)) :
                                                  int'($urandom_range(1, 4));
            send_key(1'($urandom_range(0, 1)), nblk);
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: chaining from reset state, both functions, field extremes
      send(1'b0, 1'b0, 1'b0, 16'h0000, 64'h0, 64'h0);
      send(mkbc_pkg::FUNC_DECRYPT, 1'b0, 1'b1, 16'hffff, '1, '1);
      send(1'b0, 1'b1, 1'b1, 16'h0000, 64'h0, 64'h0);
      send(mkbc_pkg::FUNC_DECRYPT, 1'b1, 1'b1, 16'hffff, '1, '1);
      send(mkbc_pkg::FUNC_DECRYPT, 1'b1, 1'b0, 16'h8001, 64'h0, '1);
      send(mkbc_pkg::FUNC_DECRYPT, 1'b0, 1'b1, 16'h7ffe, '1, 64'h0);
      // seventeen blocks: last one overflows the block count
      send(1'b0, 1'b1, 1'b0, 16'hffff, {8'hff, 56'h0}, '1);
      for (int b = 1; b < 17; b++)
         send(1'b0, 1'b0, b == 16, rand16(), rand64(), rand64());
      drain();

      write_csrs('1, '1, '1, '1, 64'd32, '1, '1);
      send(mkbc_pkg::FUNC_DECRYPT, 1'b1, 1'b1, 16'h1234, rand64(), rand64());
      random_phase(230);
      drain();

      write_csrs(rand64(), rand64(), rand64(), rand64(), 64'd63, rand64(), rand64());
      random_phase(120);
      drain();
      random_phase(120);
      drain();

      write_csrs(rand64(), rand64(), rand64(), rand64(), 64'd0, '0, '0);
      random_phase(230);
      drain();

      write_csrs(rand64(), rand64(), rand64(), rand64(), 64'd1, rand64(), rand64());
      random_phase(230);
      drain();

      write_csrs(rand64(), rand64(), rand64(), rand64(), '1, rand64(), rand64());
      random_phase(200);
      drain();

      write_csrs(rand64(), rand64(), rand64(), rand64(), 64'($urandom_range(2, 31)),
                 rand64(), rand64());
      random_phase(230);
      drain();

      $display("Covered %0d requests over %0d CSR settings plus reset values;", requests_sent,
               settings_run);
      $display("%0d responses checked, %0d bad length, %0d over block limit.", checked,
               bad_len_seen, too_many_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS mppe_key_block_cipher");
      end else begin
         $display("FAIL mppe_key_block_cipher");
      end
      $finish;
   end

endmodule
